// File: src/vlod_pkg.sv
// Types, opcode constants and decode tables shared by the opcode decoder files.
package vlod_pkg;

	typedef logic [5:0] kind_t;
	typedef logic [3:0] form_t;

	localparam int unsigned IMAGE_SIZE_W = 17;
	localparam logic [IMAGE_SIZE_W-1:0] IMAGE_SIZE_RST = 17'd65536;

	localparam kind_t K_INV   = 6'd0;
	localparam kind_t K_NOP   = 6'd1;
	localparam kind_t K_BR    = 6'd2;
	localparam kind_t K_BRF   = 6'd3;
	localparam kind_t K_LD    = 6'd4;
	localparam kind_t K_ST    = 6'd5;
	localparam kind_t K_MOV   = 6'd6;
	localparam kind_t K_LDC   = 6'd7;
	localparam kind_t K_XCH   = 6'd8;
	localparam kind_t K_PUSH  = 6'd9;
	localparam kind_t K_POP   = 6'd10;
	localparam kind_t K_CALL  = 6'd11;
	localparam kind_t K_CALLF = 6'd12;
	localparam kind_t K_CALLR = 6'd13;
	localparam kind_t K_RET   = 6'd14;
	localparam kind_t K_RETI  = 6'd15;
	localparam kind_t K_JMP   = 6'd16;
	localparam kind_t K_JMPF  = 6'd17;
	localparam kind_t K_BZ    = 6'd18;
	localparam kind_t K_BNZ   = 6'd19;
	localparam kind_t K_BE    = 6'd20;
	localparam kind_t K_BNE   = 6'd21;
	localparam kind_t K_DBNZ  = 6'd22;
	localparam kind_t K_BP    = 6'd23;
	localparam kind_t K_BPC   = 6'd24;
	localparam kind_t K_BN    = 6'd25;
	localparam kind_t K_ADD   = 6'd26;
	localparam kind_t K_ADDC  = 6'd27;
	localparam kind_t K_SUB   = 6'd28;
	localparam kind_t K_SUBC  = 6'd29;
	localparam kind_t K_INC   = 6'd30;
	localparam kind_t K_DEC   = 6'd31;
	localparam kind_t K_MUL   = 6'd32;
	localparam kind_t K_DIV   = 6'd33;
	localparam kind_t K_AND   = 6'd34;
	localparam kind_t K_OR    = 6'd35;
	localparam kind_t K_XOR   = 6'd36;
	localparam kind_t K_ROL   = 6'd37;
	localparam kind_t K_ROLC  = 6'd38;
	localparam kind_t K_ROR   = 6'd39;
	localparam kind_t K_RORC  = 6'd40;
	localparam kind_t K_SET1  = 6'd41;
	localparam kind_t K_CLR1  = 6'd42;
	localparam kind_t K_NOT1  = 6'd43;

	localparam form_t F_NONE    = 4'd0;
	localparam form_t F_I8      = 4'd1;
	localparam form_t F_D9      = 4'd2;
	localparam form_t F_IND     = 4'd3;
	localparam form_t F_A12     = 4'd4;
	localparam form_t F_A16     = 4'd5;
	localparam form_t F_R8      = 4'd6;
	localparam form_t F_R16     = 4'd7;
	localparam form_t F_D9B3    = 4'd8;
	localparam form_t F_D9B3R8  = 4'd9;
	localparam form_t F_D9R8    = 4'd10;
	localparam form_t F_INDR8   = 4'd11;
	localparam form_t F_I8R8    = 4'd12;
	localparam form_t F_D9I8    = 4'd13;
	localparam form_t F_INDI8   = 4'd14;
	localparam form_t F_INDI8R8 = 4'd15;

	localparam logic [7:0] OP_NOP   = 8'h00;
	localparam logic [7:0] OP_BR    = 8'h01;
	localparam logic [7:0] OP_RCALL = 8'h10;
	localparam logic [7:0] OP_BRF   = 8'h11;
	localparam logic [7:0] OP_FCALL = 8'h20;
	localparam logic [7:0] OP_JMPF  = 8'h21;
	localparam logic [7:0] OP_MUL   = 8'h30;
	localparam logic [7:0] OP_DIV   = 8'h40;
	localparam logic [7:0] OP_UND0  = 8'h50;
	localparam logic [7:0] OP_UND1  = 8'h51;
	localparam logic [7:0] OP_BZ    = 8'h80;
	localparam logic [7:0] OP_BNZ   = 8'h90;
	localparam logic [7:0] OP_RET   = 8'hA0;
	localparam logic [7:0] OP_RETI  = 8'hB0;
	localparam logic [7:0] OP_ROR   = 8'hC0;
	localparam logic [7:0] OP_LDC   = 8'hC1;
	localparam logic [7:0] OP_RORC  = 8'hD0;
	localparam logic [7:0] OP_ROL   = 8'hE0;
	localparam logic [7:0] OP_ROLC  = 8'hF0;

	localparam logic [2:0] FLAG_CALL = 3'b001;
	localparam logic [2:0] FLAG_RET  = 3'b010;
	localparam logic [2:0] FLAG_END  = 3'b100;

	localparam kind_t ROW_KIND [16] = '{
		K_LD, K_ST, K_MOV, K_BE, K_BNE, K_DBNZ, K_INC, K_DEC,
		K_ADD, K_ADDC, K_SUB, K_SUBC, K_XCH, K_OR, K_AND, K_XOR
	};
	localparam form_t ROW_IMM [16] = '{
		F_NONE, F_NONE, F_NONE, F_I8R8, F_I8R8, F_NONE, F_NONE, F_NONE,
		F_I8, F_I8, F_I8, F_I8, F_NONE, F_I8, F_I8, F_I8
	};
	localparam form_t ROW_DIR [16] = '{
		F_D9, F_D9, F_D9I8, F_D9R8, F_D9R8, F_D9R8, F_D9, F_D9,
		F_D9, F_D9, F_D9, F_D9, F_D9, F_D9, F_D9, F_D9
	};
	localparam form_t ROW_IND [16] = '{
		F_IND, F_IND, F_INDI8, F_INDI8R8, F_INDI8R8, F_INDR8, F_IND, F_IND,
		F_IND, F_IND, F_IND, F_IND, F_IND, F_IND, F_IND, F_IND
	};
	localparam logic [2:0] ROW_CYC [16] = '{
		3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
	};

	localparam kind_t HI_KIND [8] = '{
		K_CALL, K_JMP, K_BPC, K_BP, K_BN, K_NOT1, K_CLR1, K_SET1
	};
	localparam form_t HI_FORM [8] = '{
		F_A12, F_A12, F_D9B3R8, F_D9B3R8, F_D9B3R8, F_D9B3, F_D9B3, F_D9B3
	};
	localparam logic [2:0] HI_LONG_LIMIT = 3'd5;

	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  opcode_byte;
		logic [7:0]  second_byte;
		logic [7:0]  third_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  length;
		kind_t       op_kind;
		form_t       operand_form;
		logic [2:0]  cycle_count;
		logic [1:0]  reg_select;
		logic [2:0]  bit_select;
		logic [7:0]  immediate;
		logic [8:0]  ram_address;
		logic [15:0] branch_target;
		logic        tgt_valid;
		logic [2:0]  flow_flags;
	} result_t;

endpackage

// File: src/vlod_decode.sv
// Single-pass decode of one instruction into its result fields.
module vlod_decode import vlod_pkg::*; (
	input  item_t                   item,
	input  logic [IMAGE_SIZE_W-1:0] image_size,
	output result_t                 result
);

	logic [7:0]              b;
	logic [7:0]              b1;
	logic [7:0]              b2;
	logic [3:0]              row;
	logic [2:0]              lo;
	kind_t                   kind;
	form_t                   form;
	logic [2:0]              cyc;
	logic [1:0]              len;
	logic                    outside;
	logic                    trunc;
	logic [IMAGE_SIZE_W-1:0] span;
	logic [15:0]             next;
	logic                    d8;
	logic [7:0]              rel_off;
	logic [15:0]             rel_tgt;
	logic [15:0]             r16_tgt;
	logic [7:0]              imm;
	logic [8:0]              ram;
	logic [15:0]             tgt;
	logic                    has;
	logic [2:0]              flags;

	assign b   = item.opcode_byte;
	assign b1  = item.second_byte;
	assign b2  = item.third_byte;
	assign row = b[7:4];
	assign lo  = b[2:0];

	always_comb begin
		kind = K_INV;
		form = F_NONE;
		cyc  = 3'd1;
		if (b[3]) begin
			kind = HI_KIND[b[7:5]];
			form = HI_FORM[b[7:5]];
			cyc  = (b[7:5] < HI_LONG_LIMIT) ? 3'd2 : 3'd1;
		end else begin
			case (b)
				OP_NOP: kind = K_NOP;
				OP_BR: begin
					kind = K_BR;
					form = F_R8;
					cyc  = 3'd2;
				end
				OP_RCALL: begin
					kind = K_CALLR;
					form = F_R16;
					cyc  = 3'd4;
				end
				OP_BRF: begin
					kind = K_BRF;
					form = F_R16;
					cyc  = 3'd4;
				end
				OP_FCALL: begin
					kind = K_CALLF;
					form = F_A16;
					cyc  = 3'd2;
				end
				OP_JMPF: begin
					kind = K_JMPF;
					form = F_A16;
					cyc  = 3'd2;
				end
				OP_MUL: begin
					kind = K_MUL;
					cyc  = 3'd7;
				end
				OP_DIV: begin
					kind = K_DIV;
					cyc  = 3'd7;
				end
				OP_UND0, OP_UND1: kind = K_INV;
				OP_BZ: begin
					kind = K_BZ;
					form = F_R8;
					cyc  = 3'd2;
				end
				OP_BNZ: begin
					kind = K_BNZ;
					form = F_R8;
					cyc  = 3'd2;
				end
				OP_RET: begin
					kind = K_RET;
					cyc  = 3'd2;
				end
				OP_RETI: begin
					kind = K_RETI;
					cyc  = 3'd2;
				end
				OP_ROR: kind = K_ROR;
				OP_LDC: begin
					kind = K_LDC;
					cyc  = 3'd2;
				end
				OP_RORC: kind = K_RORC;
				OP_ROL: kind = K_ROL;
				OP_ROLC: kind = K_ROLC;
				default: begin
					kind = ROW_KIND[row];
					cyc  = ROW_CYC[row];
					if (!lo[2] && !lo[1] && (kind == K_INC || kind == K_DEC)) begin
						kind = (kind == K_INC) ? K_PUSH : K_POP;
						form = F_D9;
						cyc  = 3'd2;
					end else begin
						if (kind == K_MOV && lo[2]) begin
							cyc = 3'd1;
						end
						if (lo[2]) begin
							form = ROW_IND[row];
						end else if (lo[1]) begin
							form = ROW_DIR[row];
						end else begin
							form = ROW_IMM[row];
						end
						if (form == F_NONE) begin
							kind = K_INV;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		case (form)
			F_NONE, F_IND: len = 2'd1;
			F_I8, F_D9, F_R8, F_A12, F_D9B3, F_INDR8, F_INDI8: len = 2'd2;
			default: len = 2'd3;
		endcase
	end

	assign outside = {1'b0, item.pc} >= image_size;
	assign span    = {1'b0, item.pc} + {{(IMAGE_SIZE_W-2){1'b0}}, len};
	assign trunc   = span > image_size;
	assign next    = span[15:0];
	assign d8      = b[3] ? b[4] : b[0];
	assign rel_off = (form == F_R8 || form == F_INDR8) ? b1 : b2;
	assign rel_tgt = next + {{8{rel_off[7]}}, rel_off};
	assign r16_tgt = next + 16'hFFFF + {b2, b1};

	always_comb begin
		imm = 8'd0;
		ram = 9'd0;
		tgt = 16'd0;
		has = 1'b0;
		case (form)
			F_I8, F_INDI8: imm = b1;
			F_D9, F_D9B3: ram = {d8, b1};
			F_A12: begin
				tgt = {next[15:12], b[4], b[2:0], b1};
				has = 1'b1;
			end
			F_A16: begin
				tgt = {b1, b2};
				has = 1'b1;
			end
			F_R8, F_INDR8: begin
				tgt = rel_tgt;
				has = 1'b1;
			end
			F_R16: begin
				tgt = r16_tgt;
				has = 1'b1;
			end
			F_D9B3R8, F_D9R8: begin
				ram = {d8, b1};
				tgt = rel_tgt;
				has = 1'b1;
			end
			F_I8R8, F_INDI8R8: begin
				imm = b1;
				tgt = rel_tgt;
				has = 1'b1;
			end
			F_D9I8: begin
				ram = {d8, b1};
				imm = b2;
			end
			default: ;
		endcase
	end

	always_comb begin
		flags = 3'b000;
		if (kind == K_CALL || kind == K_CALLF || kind == K_CALLR) begin
			flags = flags | FLAG_CALL;
		end
		if (kind == K_RET || kind == K_RETI) begin
			flags = flags | FLAG_RET | FLAG_END;
		end
		if (kind == K_JMP || kind == K_JMPF || kind == K_BR || kind == K_BRF ||
			kind == K_INV) begin
			flags = flags | FLAG_END;
		end
	end

	always_comb begin
		result = '0;
		if (outside) begin
			result = '0;
		end else if (trunc) begin
			result.length      = 2'd1;
			result.cycle_count = cyc;
			result.flow_flags  = FLAG_END;
		end else begin
			result.length        = len;
			result.op_kind       = kind;
			result.operand_form  = form;
			result.cycle_count   = cyc;
			result.reg_select    = b[1:0];
			result.bit_select    = b[2:0];
			result.immediate     = imm;
			result.ram_address   = ram;
			result.branch_target = tgt;
			result.tgt_valid     = has;
			result.flow_flags    = flags;
		end
	end

endmodule

// File: src/variable_length_opcode_decoder_top.sv
// Top level of the variable-length opcode decoder: input register, decode, result register.
// Decodes one instruction per clock while result_stall is low: a transaction on the item channel
// carries a program counter and the three code bytes at it; the input register captures it,
// a single decode pass works on it, and the result register then drives its result onto the
// result channel.
// Throughput is one item per cycle; result_stall holds the result register and, once the input
// register is also full, raises item_stall. cfg_ready is always high; write image_size only
// while no item is in flight. After reset image_size is 65536.
module variable_length_opcode_decoder_top import vlod_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  item_t                   item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output result_t                 result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [IMAGE_SIZE_W-1:0] cfg_data
);

	logic [IMAGE_SIZE_W-1:0] image_size_q;
	item_t                   item_s1;
	logic                    valid_s1;
	result_t                 result_q;
	logic                    result_valid_q;
	result_t                 decoded;
	logic                    adv_out;
	logic                    take;

	assign cfg_ready  = 1'b1;
	assign adv_out    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !adv_out;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= IMAGE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			image_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (adv_out && valid_s1) begin
			result_q <= decoded;
		end
	end

	vlod_decode u_decode (
		.item       (item_s1),
		.image_size (image_size_q),
		.result     (decoded)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: src/vlod_checker.sv
// Port-level checks for the opcode decoder and their binding to the top level.
module vlod_checker import vlod_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction dropped or changed");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.length == 2'd0 |-> result == '0)
		else $error("out-of-image result has nonzero fields");

	a_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.tgt_valid |-> result.branch_target == 16'd0)
		else $error("branch target without tgt_valid");

	a_invalid_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.length != 2'd0 && result.op_kind == K_INV
		|-> result.flow_flags == FLAG_END)
		else $error("invalid instruction does not end the block");

	a_item_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item channel stalled while result side is free");

endmodule

bind variable_length_opcode_decoder_top vlod_checker u_vlod_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the variable-length opcode decoder: random and directed decode checks.
module testbench import vlod_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int ITEMS_PER_SIZE = 172;
	localparam logic [7:0] SPECIAL_OPS [19] = '{
		OP_NOP, OP_BR, OP_RCALL, OP_BRF, OP_FCALL, OP_JMPF, OP_MUL, OP_DIV, OP_UND0,
		OP_UND1, OP_BZ, OP_BNZ, OP_RET, OP_RETI, OP_ROR, OP_LDC, OP_RORC, OP_ROL, OP_ROLC
	};

	class decode_checker;
		logic [IMAGE_SIZE_W-1:0] image_size;
		result_t pending_decodes[$];
		int errors;

		function new();
			image_size = IMAGE_SIZE_RST;
			errors = 0;
		endfunction

		function void classify(input logic [7:0] op, output kind_t k, output form_t f,
				output logic [2:0] c);
			form_t fi, fd, fn;
			c = 3'd1;
			f = F_NONE;
			k = K_INV;
			if (op[3]) begin
				case (op[7:5])
					3'd0: begin k = K_CALL; f = F_A12; end
					3'd1: begin k = K_JMP;  f = F_A12; end
					3'd2: begin k = K_BPC;  f = F_D9B3R8; end
					3'd3: begin k = K_BP;   f = F_D9B3R8; end
					3'd4: begin k = K_BN;   f = F_D9B3R8; end
					3'd5: k = K_NOT1;
					3'd6: k = K_CLR1;
					default: k = K_SET1;
				endcase
				if (op[7:5] < 3'd5) c = 3'd2;
				else f = F_D9B3;
				return;
			end
			case (op)
				OP_NOP: k = K_NOP;
				OP_BR: begin k = K_BR; f = F_R8; c = 3'd2; end
				OP_RCALL: begin k = K_CALLR; f = F_R16; c = 3'd4; end
				OP_BRF: begin k = K_BRF; f = F_R16; c = 3'd4; end
				OP_FCALL: begin k = K_CALLF; f = F_A16; c = 3'd2; end
				OP_JMPF: begin k = K_JMPF; f = F_A16; c = 3'd2; end
				OP_MUL: begin k = K_MUL; c = 3'd7; end
				OP_DIV: begin k = K_DIV; c = 3'd7; end
				OP_UND0, OP_UND1: k = K_INV;
				OP_BZ: begin k = K_BZ; f = F_R8; c = 3'd2; end
				OP_BNZ: begin k = K_BNZ; f = F_R8; c = 3'd2; end
				OP_RET: begin k = K_RET; c = 3'd2; end
				OP_RETI: begin k = K_RETI; c = 3'd2; end
				OP_ROR: k = K_ROR;
				OP_LDC: begin k = K_LDC; c = 3'd2; end
				OP_RORC: k = K_RORC;
				OP_ROL: k = K_ROL;
				OP_ROLC: k = K_ROLC;
				default: begin
					fi = F_NONE;
					fd = F_D9;
					fn = F_IND;
					case (op[7:4])
						4'h0: k = K_LD;
						4'h1: k = K_ST;
						4'h2: begin k = K_MOV; fd = F_D9I8; fn = F_INDI8; c = 3'd2; end
						4'h3: begin k = K_BE; fi = F_I8R8; fd = F_D9R8; fn = F_INDI8R8; c = 3'd2; end
						4'h4: begin k = K_BNE; fi = F_I8R8; fd = F_D9R8; fn = F_INDI8R8; c = 3'd2; end
						4'h5: begin k = K_DBNZ; fd = F_D9R8; fn = F_INDR8; c = 3'd2; end
						4'h6: k = K_INC;
						4'h7: k = K_DEC;
						4'h8: begin k = K_ADD; fi = F_I8; end
						4'h9: begin k = K_ADDC; fi = F_I8; end
						4'hA: begin k = K_SUB; fi = F_I8; end
						4'hB: begin k = K_SUBC; fi = F_I8; end
						4'hC: k = K_XCH;
						4'hD: begin k = K_OR; fi = F_I8; end
						4'hE: begin k = K_AND; fi = F_I8; end
						default: begin k = K_XOR; fi = F_I8; end
					endcase
					if (op[2:1] == 2'b00 && (k == K_INC || k == K_DEC)) begin
						k = (k == K_INC) ? K_PUSH : K_POP;
						f = F_D9;
						c = 3'd2;
					end else begin
						if (k == K_MOV && op[2]) c = 3'd1;
						f = op[2] ? fn : (op[1] ? fd : fi);
						if (f == F_NONE) k = K_INV;
					end
				end
			endcase
		endfunction

		function logic [1:0] form_bytes(input form_t f);
			case (f)
				F_NONE, F_IND: return 2'd1;
				F_I8, F_D9, F_R8, F_A12, F_D9B3, F_INDR8, F_INDI8: return 2'd2;
				default: return 2'd3;
			endcase
		endfunction

		function result_t decode_instr(input item_t it);
			result_t r;
			kind_t k;
			form_t f;
			logic [2:0] c;
			logic [17:0] end_addr;
			logic [15:0] nxt, rel_b1, rel_b2;
			logic [8:0] dir_addr;
			r = '0;
			if ({1'b0, it.pc} >= image_size) return r;
			classify(it.opcode_byte, k, f, c);
			end_addr = {2'b00, it.pc} + {16'b0, form_bytes(f)};
			if (end_addr > {1'b0, image_size}) begin
				r.length = 2'd1;
				r.cycle_count = c;
				r.flow_flags = FLAG_END;
				return r;
			end
			nxt = end_addr[15:0];
			rel_b1 = nxt + {{8{it.second_byte[7]}}, it.second_byte};
			rel_b2 = nxt + {{8{it.third_byte[7]}}, it.third_byte};
			dir_addr = {it.opcode_byte[3] ? it.opcode_byte[4] : it.opcode_byte[0], it.second_byte};
			case (f)
				F_I8, F_INDI8: r.immediate = it.second_byte;
				F_D9, F_D9B3: r.ram_address = dir_addr;
				F_A12: begin
					r.branch_target = {nxt[15:12], it.opcode_byte[4], it.opcode_byte[2:0],
						it.second_byte};
					r.tgt_valid = 1'b1;
				end
				F_A16: begin
					r.branch_target = {it.second_byte, it.third_byte};
					r.tgt_valid = 1'b1;
				end
				F_R8, F_INDR8: begin
					r.branch_target = rel_b1;
					r.tgt_valid = 1'b1;
				end
				F_R16: begin
					r.branch_target = nxt + 16'hFFFF + {it.third_byte, it.second_byte};
					r.tgt_valid = 1'b1;
				end
				F_D9B3R8, F_D9R8: begin
					r.ram_address = dir_addr;
					r.branch_target = rel_b2;
					r.tgt_valid = 1'b1;
				end
				F_I8R8, F_INDI8R8: begin
					r.immediate = it.second_byte;
					r.branch_target = rel_b2;
					r.tgt_valid = 1'b1;
				end
				F_D9I8: begin
					r.ram_address = dir_addr;
					r.immediate = it.third_byte;
				end
				default: ;
			endcase
			if (k == K_CALL || k == K_CALLF || k == K_CALLR) r.flow_flags |= FLAG_CALL;
			if (k == K_RET || k == K_RETI) r.flow_flags |= FLAG_RET | FLAG_END;
			if (k == K_JMP || k == K_JMPF || k == K_BR || k == K_BRF || k == K_INV)
				r.flow_flags |= FLAG_END;
			r.length = form_bytes(f);
			r.op_kind = k;
			r.operand_form = f;
			r.cycle_count = c;
			r.reg_select = it.opcode_byte[1:0];
			r.bit_select = it.opcode_byte[2:0];
			return r;
		endfunction

		function void note_item(input item_t it);
			pending_decodes.push_back(decode_instr(it));
		endfunction

		function void cmp_field(input string name, input int unsigned e, input int unsigned g);
			if (e != g) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, g);
			end
		endfunction

		function void check_result(input result_t got);
			result_t e;
			if (pending_decodes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
				return;
			end
			e = pending_decodes.pop_front();
			cmp_field("length", 32'(e.length), 32'(got.length));
			cmp_field("op_kind", 32'(e.op_kind), 32'(got.op_kind));
			cmp_field("operand_form", 32'(e.operand_form), 32'(got.operand_form));
			cmp_field("cycle_count", 32'(e.cycle_count), 32'(got.cycle_count));
			cmp_field("reg_select", 32'(e.reg_select), 32'(got.reg_select));
			cmp_field("bit_select", 32'(e.bit_select), 32'(got.bit_select));
			cmp_field("immediate", 32'(e.immediate), 32'(got.immediate));
			cmp_field("ram_address", 32'(e.ram_address), 32'(got.ram_address));
			cmp_field("branch_target", 32'(e.branch_target), 32'(got.branch_target));
			cmp_field("tgt_valid", 32'(e.tgt_valid), 32'(got.tgt_valid));
			cmp_field("flow_flags", 32'(e.flow_flags), 32'(got.flow_flags));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IMAGE_SIZE_W-1:0] cfg_data = '0;

	decode_checker chk = new();
	int quiet_cycles = 0;
	int stall_left = 0;
	bit stall_on = 1'b0;
	bit no_gaps = 1'b0;

	variable_length_opcode_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) chk.note_item(item);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) chk.check_result(result);
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_on = !stall_on;
			if (stall_on)
				stall_left = ($urandom_range(0, 99) < 10) ? $urandom_range(15, 60) :
					$urandom_range(1, 3);
			else
				stall_left = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 300) :
					$urandom_range(1, 12);
		end
		result_stall <= stall_on;
		stall_left--;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task send_item(input item_t it);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
	endtask

	task idle_gap();
		int r, n;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) n = 0;
		else if (r < 88) n = $urandom_range(1, 3);
		else if (r < 97) n = $urandom_range(4, 12);
		else n = $urandom_range(20, 50);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task wait_drained();
		item_valid <= 1'b0;
		while (chk.pending_decodes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_image_size(input logic [IMAGE_SIZE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		chk.image_size = v;
		cfg_valid <= 1'b0;
	endtask

	function logic [7:0] pick_byte();
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'h7F;
				2: return 8'h80;
				default: return 8'hFF;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function item_t rand_item();
		item_t it;
		int r, p;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			p = int'(chk.image_size) + 1 - int'($urandom_range(0, 5));
			if (p < 0) p = 0;
			if (p > 65535) p = 65535 - int'($urandom_range(0, 3));
			it.pc = 16'(p);
		end else if (r < 45) begin
			it.pc = ($urandom_range(0, 1) == 1) ? 16'(16'hFFFF - $urandom_range(0, 3)) :
				16'($urandom_range(0, 3));
		end else begin
			it.pc = 16'($urandom_range(0, 65535));
		end
		it.opcode_byte = ($urandom_range(0, 99) < 30) ?
			SPECIAL_OPS[$urandom_range(0, 18)] : 8'($urandom_range(0, 255));
		it.second_byte = pick_byte();
		it.third_byte = pick_byte();
		return it;
	endfunction

	initial begin
		item_t directed[$];
		logic [IMAGE_SIZE_W-1:0] sizes[$];
		directed = '{
			'{16'h0000, OP_NOP, 8'hFF, 8'hFF},
			'{16'h0000, OP_BR, 8'h80, 8'h00},
			'{16'h1234, OP_BR, 8'h7F, 8'h00},
			'{16'h0010, OP_RCALL, 8'h00, 8'h00},
			'{16'h8000, OP_BRF, 8'hFF, 8'hFF},
			'{16'hFFFD, OP_JMPF, 8'hAB, 8'hCD},
			'{16'hFFFE, OP_FCALL, 8'h12, 8'h34},
			'{16'h0100, OP_MUL, 8'h55, 8'hAA},
			'{16'h0101, OP_DIV, 8'hAA, 8'h55},
			'{16'h0102, OP_UND0, 8'hFF, 8'hFF},
			'{16'h0103, OP_UND1, 8'hFF, 8'hFF},
			'{16'hFFFE, OP_BZ, 8'h01, 8'h00},
			'{16'h0200, OP_BNZ, 8'hFE, 8'h00},
			'{16'h0300, OP_RET, 8'h00, 8'h00},
			'{16'h0301, OP_RETI, 8'h00, 8'h00},
			'{16'h0302, OP_ROR, 8'h00, 8'h00},
			'{16'h0303, OP_LDC, 8'h00, 8'h00},
			'{16'h0304, OP_RORC, 8'h00, 8'h00},
			'{16'h0305, OP_ROL, 8'h00, 8'h00},
			'{16'h0306, OP_ROLC, 8'h00, 8'h00},
			'{16'hF7FE, 8'h1F, 8'hFF, 8'h00},
			'{16'hFFFF, 8'hFF, 8'h12, 8'h34},
			'{16'h2000, 8'h5A, 8'hFF, 8'h80},
			'{16'h0003, 8'h23, 8'h9C, 8'hE1},
			'{16'h0005, 8'h61, 8'h42, 8'h00},
			'{16'h0007, 8'h57, 8'h80, 8'h00}
		};
		sizes = '{IMAGE_SIZE_RST, 17'd0, 17'd1, 17'd3, 17'd65535, 17'h1FFFF, 17'd2,
			17'($urandom_range(4, 65534))};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_item(directed[i]);
			idle_gap();
		end
		wait_drained();

		foreach (sizes[s]) begin
			write_image_size(sizes[s]);
			no_gaps = (s % 3 == 2);
			for (int n = 0; n < ITEMS_PER_SIZE; n++) begin
				send_item(rand_item());
				idle_gap();
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		chk.errors += chk.pending_decodes.size();
		if (chk.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
src/vlod_pkg.sv
src/vlod_decode.sv
src/variable_length_opcode_decoder_top.sv
src/vlod_checker.sv
tb/testbench.sv
